// ===== hw/rtl/lif_pkg.sv =====
// ----------------------------------------------------------------------------
// lif_pkg
// Shared widths, fixed-point constants and register indexes for the
// leaky integrate-and-fire neuron step block.
// ----------------------------------------------------------------------------
`default_nettype none

package lif_pkg;

    // field widths
    localparam int IDX_W   = 10;
    localparam int CUR_W   = 24;
    localparam int V_W     = 23;
    localparam int T_W     = 24;
    localparam int DECAY_W = 16;
    localparam int INV_W   = 20;
    localparam int CFG_W   = 24;
    localparam int CFG_AW  = 2;

    // fixed-point constants
    localparam logic [24:0] ONE_T = 25'd16777216;   // 1.0 in Q1.24
    localparam logic [22:0] ONE_V = 23'd65536;      // 1.0 in Q7.16
    localparam logic [22:0] V_MAX = 23'h7FFFFF;
    localparam logic [23:0] T_MAX = 24'hFFFFFF;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] REG_DECAY   = 2'd0;
    localparam logic [CFG_AW-1:0] REG_TSTEP   = 2'd1;
    localparam logic [CFG_AW-1:0] REG_INVSTEP = 2'd2;
    localparam logic [CFG_AW-1:0] REG_REFRAC  = 2'd3;

endpackage

`default_nettype wire

// ===== hw/rtl/lif_neuron_step.sv =====
// ----------------------------------------------------------------------------
// lif_neuron_step
// Bank of leaky integrate-and-fire neurons, one neuron update per item.
// ----------------------------------------------------------------------------
// Each item names a neuron and carries its input current; the block returns
// one item with the index and a spike flag. Voltage and refractory time live
// in one on-chip memory of NEURONS words. After reset a clearing pass zeroes
// the memory, one word per cycle, and no item is taken until it is done.
// All products go through one shared 26x26 multiplier under a small
// sequencer: decay product, refractory product, scale factor, voltage
// product and spike test; on a spike the 24-step restoring divider runs if
// the overshoot needs it, then the time product and refractory reload.
// Out-of-range indexes go straight to write-back. The block is ready for
// the next item in the cycle after the result is registered; a result left
// waiting at the output holds the block. One item is in flight at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module lif_neuron_step #(
    parameter int NEURONS = 1024
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // configuration
    input  wire logic                         i_cfg_we,
    input  wire logic [lif_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  wire logic [lif_pkg::CFG_W-1:0]    i_cfg_wdata,
    // input stream
    input  wire logic                         i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  wire logic [39:0]                  i_s_axis_tdata,  // neuron_index, input_current
    // output stream
    output logic                              o_m_axis_tvalid,
    input  wire logic                         i_m_axis_tready,
    output logic [15:0]                       o_m_axis_tdata   // neuron_out, spike
);
    import lif_pkg::*;

    localparam int AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
    localparam int MW = V_W + T_W;

    // sequencer states
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_LOAD  = 4'd2;
    localparam logic [3:0] S_DV    = 4'd3;
    localparam logic [3:0] S_RM    = 4'd4;
    localparam logic [3:0] S_M     = 4'd5;
    localparam logic [3:0] S_VM    = 4'd6;
    localparam logic [3:0] S_SPK   = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_T     = 4'd9;
    localparam logic [3:0] S_R     = 4'd10;
    localparam logic [3:0] S_WB    = 4'd11;

    // configuration registers
    logic [DECAY_W-1:0] r_decay;
    logic [T_W-1:0]     r_tstep;
    logic [INV_W-1:0]   r_invstep;
    logic [T_W-1:0]     r_refrac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay   <= 16'd3277;
            r_tstep   <= 24'd16777;
            r_invstep <= 20'd1000;
            r_refrac  <= 24'd33554;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_DECAY:   r_decay   <= i_cfg_wdata[DECAY_W-1:0];
                REG_TSTEP:   r_tstep   <= i_cfg_wdata[T_W-1:0];
                REG_INVSTEP: r_invstep <= i_cfg_wdata[INV_W-1:0];
                REG_REFRAC:  r_refrac  <= i_cfg_wdata[T_W-1:0];
                default: ;
            endcase
        end
    end

    logic [3:0]           r_state, n_state;
    logic [AW-1:0]        r_clr;
    logic [IDX_W-1:0]     r_idx;
    logic signed [CUR_W-1:0] r_cur;
    logic [AW-1:0]        r_addr;
    logic [MW-1:0]        r_rd;
    logic signed [24:0]   r_dv;
    logic [V_W-1:0]       r_v;
    logic [T_W-1:0]       r_r;
    logic [24:0]          r_m;
    logic [24:0]          r_ov;
    logic signed [51:0]   r_prod;
    logic                 r_spike;
    logic                 r_skip;
    logic                 r_ovalid;
    logic [IDX_W-1:0]     r_oidx;
    logic                 r_ospike;
    logic [MW-1:0]        r_mem [NEURONS];

    // input unpacking and range check
    logic [IDX_W-1:0]     w_in_idx;
    logic [IDX_W+AW-1:0]  w_idx_ext;
    logic                 w_in_range;
    logic                 w_accept;

    assign w_in_idx   = i_s_axis_tdata[IDX_W-1:0];
    assign w_idx_ext  = {{AW{1'b0}}, w_in_idx};
    assign w_in_range = {7'd0, w_in_idx} < 17'(NEURONS);
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;

    // shared multiplier operand select
    logic signed [25:0] w_op_a, w_op_b;
    logic signed [24:0] w_diff;

    assign w_diff = 25'(r_cur) - $signed({2'b00, r_rd[MW-1:T_W]});

    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        case (r_state)
            S_LOAD: begin
                w_op_a = $signed({10'd0, r_decay});
                w_op_b = 26'(w_diff);
            end
            S_RM: begin
                w_op_a = $signed({2'b00, r_r});
                w_op_b = $signed({6'd0, r_invstep});
            end
            S_VM: begin
                w_op_a = $signed({3'b000, r_v});
                w_op_b = $signed({1'b0, r_m});
            end
            S_T: begin
                w_op_a = $signed({2'b00, r_tstep});
                w_op_b = $signed({1'b0, ONE_T - r_ov});
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_op_a * w_op_b;
    end

    // voltage and refractory update after the decay product
    logic signed [24:0] w_dv;
    logic signed [25:0] w_vsum;
    logic [V_W-1:0]     w_v1;
    logic [T_W-1:0]     w_r1;
    logic [T_W-1:0]     w_rold;

    assign w_dv   = r_prod[40:16];
    assign w_vsum = $signed({3'b000, r_rd[MW-1:T_W]}) + 26'(w_dv);
    assign w_rold = r_rd[T_W-1:0];
    assign w_r1   = (w_rold > r_tstep) ? (w_rold - r_tstep) : '0;

    always_comb begin
        if (w_vsum < 0) begin
            w_v1 = '0;
        end else if (w_vsum > $signed({3'b000, V_MAX})) begin
            w_v1 = V_MAX;
        end else begin
            w_v1 = w_vsum[V_W-1:0];
        end
    end

    // refractory scale factor
    logic [24:0] w_m;
    assign w_m = (r_prod[43:24] != '0) ? '0 : (ONE_T - {1'b0, r_prod[23:0]});

    // spike test and overshoot setup
    logic [V_W-1:0] w_v2;
    logic           w_fire;
    logic [24:0]    w_over;
    logic           w_dv_pos;
    logic           w_ov_sat;

    assign w_v2     = r_prod[46:24];
    assign w_fire   = w_v2 > ONE_V;
    assign w_over   = {2'b00, w_v2 - ONE_V};
    assign w_dv_pos = !r_dv[24] && (r_dv != '0);
    assign w_ov_sat = w_over >= r_dv;

    // overshoot divider
    logic        w_div_start;
    logic        w_div_done;
    logic [23:0] w_quot;

    assign w_div_start = (r_state == S_SPK) && w_fire && w_dv_pos && !w_ov_sat;

    lif_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_over),
        .i_den   (r_dv),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // refractory reload after a spike
    logic [24:0] w_rsum;
    assign w_rsum = {1'b0, r_refrac} + {1'b0, r_prod[47:24]};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == AW'(NEURONS - 1)) n_state = S_IDLE;
            S_IDLE:  if (w_accept) n_state = w_in_range ? S_LOAD : S_WB;
            S_LOAD:  n_state = S_DV;
            S_DV:    n_state = S_RM;
            S_RM:    n_state = S_M;
            S_M:     n_state = S_VM;
            S_VM:    n_state = S_SPK;
            S_SPK: begin
                if (!w_fire) begin
                    n_state = S_WB;
                end else if (w_div_start) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_T;
                end
            end
            S_DIV:   if (w_div_done) n_state = S_T;
            S_T:     n_state = S_R;
            S_R:     n_state = S_WB;
            S_WB:    if (!r_ovalid || i_m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + AW'(1);
            if (r_state == S_WB && (!r_ovalid || i_m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_idx   <= w_in_idx;
            r_cur   <= i_s_axis_tdata[IDX_W+CUR_W-1:IDX_W];
            r_addr  <= w_idx_ext[AW-1:0];
            r_skip  <= !w_in_range;
            r_spike <= 1'b0;
        end
        case (r_state)
            S_DV: begin
                r_dv <= w_dv;
                r_v  <= w_v1;
                r_r  <= w_r1;
            end
            S_M: r_m <= w_m;
            S_SPK: begin
                // scaled voltage is kept, or cleared on a spike
                r_spike <= w_fire;
                r_ov    <= (w_dv_pos && w_ov_sat) ? ONE_T : '0;
                r_v     <= w_fire ? '0 : w_v2;
            end
            S_DIV: if (w_div_done) r_ov <= {1'b0, w_quot};
            S_R:   r_r <= w_rsum[24] ? T_MAX : w_rsum[T_W-1:0];
            S_WB: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    r_oidx   <= r_idx;
                    r_ospike <= r_spike && !r_skip;
                end
            end
            default: ;
        endcase
    end

    // neuron state memory: clear pass, read at accept, write back at the end
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            r_mem[r_clr] <= '0;
        end else if (r_state == S_WB && !r_skip && (!r_ovalid || i_m_axis_tready)) begin
            r_mem[r_addr] <= {r_v, r_r};
        end
        if (w_accept) r_rd <= r_mem[w_idx_ext[AW-1:0]];
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {5'd0, r_ospike, r_oidx};

endmodule

`default_nettype wire

// ===== hw/rtl/lif_div.sv =====
// ----------------------------------------------------------------------------
// lif_div
// Restoring divider for the spike overshoot: q = floor(a * 2^24 / d), with
// a < d assumed, one quotient bit per cycle for 24 quotient bits.
// ----------------------------------------------------------------------------
`default_nettype none

module lif_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [24:0] i_num,
    input  wire logic [24:0] i_den,
    output logic             o_done,
    output logic [23:0]      o_quot
);
    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [24:0] r_rem;
    logic [24:0] r_den;
    logic [23:0] r_quot;
    logic        r_done;

    logic [25:0] w_shift;
    logic [25:0] w_sub;
    logic        w_ge;

    // one trial subtract per cycle
    assign w_shift = {r_rem, 1'b0};
    assign w_sub   = w_shift - {1'b0, r_den};
    assign w_ge    = w_shift >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd23) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_sub[24:0] : w_shift[24:0];
            r_quot <= {r_quot[22:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire
